/* hw/rtl/assert_macros.svh */
// assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, ignored while reset is high
`define FPSD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define FPSD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/fpsd_pkg.sv */
// shared types and constants of the four prime sum decomposer
package fpsd_pkg;

  localparam int unsigned TargetW = 16;
  localparam int unsigned PrimeW  = 16;
  localparam int unsigned OutW    = 72;
  localparam int unsigned MapMax  = 65535;

  localparam logic [TargetW-1:0] SmallTarget = 16'd8;
  localparam logic [TargetW-1:0] OddOffset   = 16'd5;
  localparam logic [TargetW-1:0] EvenOffset  = 16'd4;
  localparam logic [PrimeW-1:0]  PrimeTwo    = 16'd2;
  localparam logic [PrimeW-1:0]  PrimeThree  = 16'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_SV_READ,
    ST_SV_TEST,
    ST_MARK,
    ST_IDLE,
    ST_Q_READ,
    ST_Q_TEST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr_write;
    logic sv_rd;
    logic mark_start;
    logic mark_write;
    logic sv_next;
    logic q_load;
    logic q_rd;
    logic q_next;
    logic q_miss;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sv_prime;
    logic mark_done;
    logic sq_over;
    logic small_in;
    logic pair_found;
    logic p_last;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/fpsd_ctrl.sv */
// controller state machine: sieve build after reset, then query walk
module fpsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  fpsd_pkg::status_t sts,
  output fpsd_pkg::cmd_t    cmd
);
  import fpsd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_SV_READ;
        end
      end
      ST_SV_READ: begin
        cmd.sv_rd  = 1'b1;
        state_next = ST_SV_TEST;
      end
      ST_SV_TEST: begin
        if (sts.sv_prime) begin
          cmd.mark_start = 1'b1;
          state_next     = ST_MARK;
        end else begin
          cmd.sv_next = 1'b1;
          state_next  = sts.sq_over ? ST_IDLE : ST_SV_READ;
        end
      end
      ST_MARK: begin
        if (sts.mark_done) begin
          cmd.sv_next = 1'b1;
          state_next  = sts.sq_over ? ST_IDLE : ST_SV_READ;
        end else begin
          cmd.mark_write = 1'b1;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.q_load = 1'b1;
          state_next = sts.small_in ? ST_FINISH : ST_Q_READ;
        end
      end
      ST_Q_READ: begin
        cmd.q_rd   = 1'b1;
        state_next = ST_Q_TEST;
      end
      ST_Q_TEST: begin
        if (sts.pair_found) begin
          state_next = ST_FINISH;
        end else if (sts.p_last) begin
          cmd.q_miss = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.q_next = 1'b1;
          state_next = ST_Q_READ;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* hw/rtl/fpsd_datapath.sv */
// datapath: composite bitmap memory, sieve counters, pair pointers, result register
module fpsd_datapath #(
  parameter int unsigned LIMIT = 65535
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fpsd_pkg::cmd_t                    cmd,
  output fpsd_pkg::status_t                 sts,
  input  logic [fpsd_pkg::TargetW-1:0]      s_tdata,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [fpsd_pkg::OutW-1:0]         m_tdata
);
  import fpsd_pkg::*;

  localparam int unsigned Bound = (LIMIT < MapMax) ? LIMIT : MapMax;
  localparam int unsigned Depth = Bound + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [16:0] BoundW = 17'(Bound);

  logic map_mem [Depth];

  logic [AW-1:0] clr_addr;
  logic [8:0]    sv_i;
  logic [16:0]   sv_sq;
  logic [16:0]   sv_j;
  logic [16:0]   sq_next;

  logic [PrimeW-1:0] p_ptr;
  logic [PrimeW-1:0] q_ptr;
  logic [PrimeW-1:0] half;
  logic [PrimeW-1:0] rem;
  logic [PrimeW-1:0] res_a;
  logic [PrimeW-1:0] res_b;
  logic              res_imp;
  logic              res_nf;

  logic          rd_a;
  logic          rd_b;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic [AW-1:0] ra_addr;
  logic          q_ok;
  logic          odd_in;

  assign sq_next = sv_sq + {7'd0, sv_i, 1'b1};
  assign odd_in  = s_tdata[0];
  assign rem     = s_tdata - (odd_in ? OddOffset : EvenOffset);

  // single write port shared by the clearing pass and the sieve marking
  assign wr_en   = cmd.clr_write | cmd.mark_write;
  assign wr_addr = cmd.clr_write ? clr_addr : AW'(sv_j);
  assign wr_data = cmd.clr_write ? (clr_addr < AW'(2)) : 1'b1;
  assign ra_addr = cmd.sv_rd ? AW'(sv_i) : AW'(p_ptr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (cmd.sv_rd || cmd.q_rd) begin
      rd_a <= map_mem[ra_addr];
    end
    if (cmd.q_rd) begin
      rd_b <= map_mem[AW'(q_ptr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      sv_i     <= 9'd2;
      sv_sq    <= 17'd4;
    end else begin
      if (cmd.clr_write) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.sv_next) begin
        sv_i  <= sv_i + 9'd1;
        sv_sq <= sq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_start) begin
      sv_j <= sv_sq;
    end else if (cmd.mark_write) begin
      sv_j <= sv_j + {8'd0, sv_i};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      p_ptr   <= PrimeTwo;
      q_ptr   <= rem - PrimeTwo;
      half    <= {1'b0, rem[PrimeW-1:1]};
      res_imp <= sts.small_in;
      res_nf  <= 1'b0;
      res_a   <= sts.small_in ? '0 : PrimeTwo;
      res_b   <= sts.small_in ? '0 : (odd_in ? PrimeThree : PrimeTwo);
    end else begin
      if (cmd.q_next) begin
        p_ptr <= p_ptr + PrimeW'(1);
        q_ptr <= q_ptr - PrimeW'(1);
      end
      if (cmd.q_miss) begin
        res_nf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {6'd0,
                  (res_imp || res_nf) ? '0 : q_ptr,
                  (res_imp || res_nf) ? '0 : p_ptr,
                  res_b, res_a, res_nf, res_imp};
    end
  end

  // q above the map bound is not a table prime; p <= q keeps p in range
  assign q_ok = {1'b0, q_ptr} <= BoundW;

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_addr == AW'(Bound));
    sts.sv_prime   = !rd_a;
    sts.mark_done  = sv_j > BoundW;
    sts.sq_over    = sq_next > BoundW;
    sts.small_in   = s_tdata < SmallTarget;
    sts.pair_found = !rd_a && !rd_b && q_ok;
    sts.p_last     = (p_ptr == half);
    sts.out_free   = !m_tvalid || m_tready;
  end

endmodule

/* hw/rtl/four_prime_sum_decomposer.sv */
// top level of the four prime sum decomposer
//
// usage: one 16-bit target per input item on the s_ channel, one result item
// per target on the m_ channel. a target below 8 returns impossible with all
// other fields zero. an odd target returns 2, 3, p, q with p + q = n - 5, an
// even one 2, 2, p, q with p + q = n - 4, where p is the smallest prime whose
// partner q is prime with q >= p; without such a pair not_found is set and
// prime_c, prime_d are zero.
// reset: a clearing pass writes all min(LIMIT, 65535) + 1 bitmap entries, one
// per cycle, then a sieve of eratosthenes marks composites one write per cycle;
// s_tready stays low until done.
// flow: a small target goes straight to the result; otherwise k candidates p are
// tried, each with one registered read of both bitmap ports and then one test.
// one target is in work at a time, so the next target is taken only once the
// result of the last one is loaded into the output register.
// stall: the result sits in an output register; while it waits on m_tready the
// next target is already accepted and walked, and only its delivery waits.
module four_prime_sum_decomposer #(
  parameter int unsigned LIMIT = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] target
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [0] impossible, [1] not_found, [17:2] prime_a,
                                 // [33:18] prime_b, [49:34] prime_c, [65:50] prime_d,
                                 // [71:66] zero
);
  import fpsd_pkg::*;

  // command and status bundles between controller and datapath
  cmd_t    cmd;
  status_t sts;

  fpsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpsd_datapath #(
    .LIMIT (LIMIT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

/* hw/rtl/fpsd_checker.sv */
// port checker for the four prime sum decomposer and its bind
`include "assert_macros.svh"

module fpsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  logic in_wait;
  logic out_wait;
  logic out_imp;
  logic out_nf;
  logic out_pair;
  logic nf_shape;
  logic pair_shape;

  assign in_wait    = s_tvalid && !s_tready;
  assign out_wait   = m_tvalid && !m_tready;
  assign out_imp    = m_tvalid && m_tdata[0];
  assign out_nf     = m_tvalid && m_tdata[1];
  assign out_pair   = m_tvalid && !m_tdata[0] && !m_tdata[1];
  // not found keeps prime_a and clears the pair
  assign nf_shape   = (m_tdata[65:34] == 32'd0) && (m_tdata[17:2] == 16'd2);
  // found pair is ordered and starts at two or more
  assign pair_shape = (m_tdata[49:34] <= m_tdata[65:50]) && (m_tdata[49:34] >= 16'd2);

  // waiting target holds
  `FPSD_ASSERT(a_in_hold, clk, rst, in_wait |=> s_tvalid && $stable(s_tdata), "target not held")

  // stalled result holds
  `FPSD_ASSERT(a_out_hold, clk, rst, out_wait |=> m_tvalid && $stable(m_tdata), "result not held")

  // impossible result carries nothing else
  `FPSD_ASSERT(a_imp_clean, clk, rst, out_imp |-> m_tdata[71:1] == 71'd0, "impossible with data")

  `FPSD_ASSERT(a_nf_pair, clk, rst, out_nf |-> nf_shape, "not found result malformed")

  `FPSD_ASSERT(a_pair_order, clk, rst, out_pair |-> pair_shape, "pair out of order")

endmodule

bind four_prime_sum_decomposer fpsd_checker u_fpsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
